@@ hdl/morse_key_decoder_defines.svh @@
// Assertion macros shared by the morse key decoder RTL.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef MORSE_KEY_DECODER_DEFINES_SVH
`define MORSE_KEY_DECODER_DEFINES_SVH

// cond must never hold outside reset
`define MKD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// ante in one cycle implies cons in the same cycle
`define MKD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante in one cycle implies cons in the next cycle
`define MKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/mkd_pkg.sv @@
// Types, constants and the Morse symbol table for the morse key decoder.
// No dependencies.
package mkd_pkg;

  localparam int DUR_W    = 16;
  localparam int SYM_W    = 6;
  localparam int CNT_W    = 4;
  localparam int LOOKUP_W = 16;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int NUM_SYMBOLS = 39;

  localparam logic [SYM_W-1:0] SYM_UNKNOWN = 6'd39;

  localparam logic [1:0] REG_DASH   = 2'd0;
  localparam logic [1:0] REG_IGNORE = 2'd1;
  localparam logic [1:0] REG_END    = 2'd2;

  localparam logic [DUR_W-1:0] DASH_RESET   = 16'd300;
  localparam logic [DUR_W-1:0] IGNORE_RESET = 16'd1000;
  localparam logic [DUR_W-1:0] END_RESET    = 16'd2000;

  typedef enum logic [1:0] {
    OP_DOT  = 2'd0,
    OP_DASH = 2'd1,
    OP_END  = 2'd2
  } mkd_op_t;

  typedef struct packed {
    logic    valid;
    mkd_op_t op;
  } mkd_qent_t;

  typedef struct packed {
    logic [DUR_W-1:0] dash;
    logic [DUR_W-1:0] ignore;
    logic [DUR_W-1:0] fin;
  } mkd_thr_t;

  // element codes: first element is MSB, dash = 1
  localparam logic [8:0] SYM_CODE [NUM_SYMBOLS] = '{
    9'd1,  9'd8,  9'd10, 9'd4,  9'd0,  9'd2,  9'd6,  9'd0,  9'd0,
    9'd7,  9'd5,  9'd4,  9'd3,  9'd2,  9'd7,  9'd6,  9'd13, 9'd2,
    9'd0,  9'd1,  9'd1,  9'd1,  9'd3,  9'd9,  9'd11, 9'd12,
    9'd31, 9'd15, 9'd7,  9'd3,  9'd1,  9'd0,  9'd16, 9'd24, 9'd28, 9'd30,
    9'd56, 9'd17, 9'd10
  };

  localparam logic [CNT_W-1:0] SYM_LEN [NUM_SYMBOLS] = '{
    4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2,
    4'd4, 4'd3, 4'd4, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd3,
    4'd3, 4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd9, 4'd5, 4'd5
  };

  function automatic logic [SYM_W-1:0] mkd_lookup(input logic [LOOKUP_W-1:0] bits,
                                                  input logic [CNT_W-1:0]    cnt);
    logic [SYM_W-1:0] res;
    res = SYM_UNKNOWN;
    for (int s = NUM_SYMBOLS - 1; s >= 0; s--) begin
      if (cnt == SYM_LEN[s] && bits == {{(LOOKUP_W-9){1'b0}}, SYM_CODE[s]}) begin
        res = SYM_W'(s);
      end
    end
    return res;
  endfunction

endpackage

@@ hdl/mkd_if.sv @@
// Valid/ready channel interfaces for key releases and decoded symbols.
// Depends on mkd_pkg.
interface mkd_key_if import mkd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] press_duration_ms;
  modport source (output valid, output press_duration_ms, input ready);
  modport sink   (input valid, input press_duration_ms, output ready);
endinterface

interface mkd_sym_if import mkd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_index;
  modport source (output valid, output symbol_index, input ready);
  modport sink   (input valid, input symbol_index, output ready);
endinterface

@@ hdl/mkd_front.sv @@
// Front end: accepts key releases and classifies them against the thresholds.
// Depends on mkd_pkg and mkd_key_if.
module mkd_front import mkd_pkg::*; (
  mkd_key_if.sink   key_in,
  input  mkd_thr_t  thr,
  input  logic      q_full,
  output mkd_qent_t push
);

  logic    drop;
  mkd_op_t op;

  // end test first, then ignore, then dash
  always_comb begin
    drop = 1'b0;
    op   = OP_DOT;
    if (key_in.press_duration_ms > thr.fin) begin
      op = OP_END;
    end else if (key_in.press_duration_ms > thr.ignore) begin
      drop = 1'b1;
    end else if (key_in.press_duration_ms > thr.dash) begin
      op = OP_DASH;
    end
  end

  assign key_in.ready = !q_full;
  assign push.valid   = key_in.valid && !q_full && !drop;
  assign push.op      = op;

endmodule

@@ hdl/mkd_queue.sv @@
// Two-entry queue of classified operations between front and back end.
// Depends on mkd_pkg and morse_key_decoder_defines.svh.
`include "morse_key_decoder_defines.svh"

module mkd_queue import mkd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mkd_qent_t push,
  input  logic      pop,
  output logic      full,
  output mkd_qent_t head
);

  mkd_op_t           slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.op;
    end
  end

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.op    = slots[rd_ptr];

  `MKD_ASSERT_NEVER(a_q_no_push_full, push.valid && full, "push into full queue")
  `MKD_ASSERT_NEVER(a_q_no_pop_empty, pop && !head.valid, "pop from empty queue")
  `MKD_ASSERT_NEVER(a_q_count_range, count > QCNT_W'(QDEPTH), "queue count out of range")

endmodule

@@ hdl/mkd_back.sv @@
// Back end: applies dot/dash/end operations to the sequence, decodes on end.
// Depends on mkd_pkg, mkd_sym_if and morse_key_decoder_defines.svh.
`include "morse_key_decoder_defines.svh"

module mkd_back import mkd_pkg::*; #(
  parameter int MAX_ELEMENTS = 9
) (
  input  logic       clk,
  input  logic       rst,
  input  mkd_qent_t  head,
  output logic       pop,
  mkd_sym_if.source  sym_out
);

  logic [MAX_ELEMENTS-1:0] element_bits;
  logic [CNT_W-1:0]        element_count;
  logic                    length_overflow;
  logic                    out_valid;
  logic [SYM_W-1:0]        out_sym;

  logic             slot_free;
  logic             is_end;
  logic             seq_full;
  logic [SYM_W-1:0] sym_next;

  assign slot_free = !out_valid || sym_out.ready;
  assign is_end    = (head.op == OP_END);
  assign seq_full  = (element_count >= CNT_W'(MAX_ELEMENTS));
  assign pop       = head.valid && (!is_end || slot_free);

  always_comb begin
    if (length_overflow || element_count == '0) begin
      sym_next = SYM_UNKNOWN;
    end else begin
      sym_next = mkd_lookup({{(LOOKUP_W-MAX_ELEMENTS){1'b0}}, element_bits}, element_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_bits    <= '0;
      element_count   <= '0;
      length_overflow <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // result stays until taken; a decode refills the slot
      out_valid <= (out_valid && !sym_out.ready) || (pop && is_end);
      if (pop) begin
        if (is_end) begin
          element_bits    <= '0;
          element_count   <= '0;
          length_overflow <= 1'b0;
        end else if (seq_full) begin
          length_overflow <= 1'b1;
        end else begin
          element_bits  <= {element_bits[MAX_ELEMENTS-2:0], head.op == OP_DASH};
          element_count <= element_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_end) begin
      out_sym <= sym_next;
    end
  end

  assign sym_out.valid        = out_valid;
  assign sym_out.symbol_index = out_sym;

  `MKD_ASSERT_NEVER(a_cnt_range, element_count > CNT_W'(MAX_ELEMENTS),
                    "element count above maximum")
  `MKD_ASSERT_IMPL(a_ovf_full, length_overflow, element_count == CNT_W'(MAX_ELEMENTS),
                   "overflow set with sequence not full")
  `MKD_ASSERT_NEXT(a_end_clears, pop && is_end,
                   element_count == '0 && !length_overflow && out_valid,
                   "decode did not clear sequence or post a result")
  `MKD_ASSERT_IMPL(a_no_drop_result, out_valid && !sym_out.ready, !(pop && is_end),
                   "decode would overwrite a pending result")

endmodule

@@ hdl/morse_key_decoder.sv @@
// Flow: a key release that ends a character is written into the queue, then decoded into
// the output register, from which its symbol shows on sym_out.
// Throughput: one key release per cycle while the queue is not full; the two-entry queue
// and the output register keep input and output stalls apart. Reset (rst, synchronous,
// active high) clears the sequence, the queue and the output valid and loads the thresholds
// with 300, 1000, 2000 ms. Depends on mkd_pkg, mkd_if, mkd_front, mkd_queue and mkd_back.
module morse_key_decoder import mkd_pkg::*; #(
  parameter int MAX_ELEMENTS = 9
) (
  input  logic              clk,
  input  logic              rst,
  mkd_key_if.sink           key_in,
  mkd_sym_if.source         sym_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // Threshold registers; the user must write them only while the decoder is idle (the block
  // does not enforce this), so the front end can compare against them directly at transfer time.
  mkd_thr_t  thr;
  logic      cfg_wr;
  logic [1:0] reg_sel;

  // queue handshake between front and back
  mkd_qent_t push;
  mkd_qent_t head;
  logic      q_full;
  logic      pop;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.dash   <= DASH_RESET;
      thr.ignore <= IGNORE_RESET;
      thr.fin    <= END_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DASH:   thr.dash   <= pwdata[DUR_W-1:0];
        REG_IGNORE: thr.ignore <= pwdata[DUR_W-1:0];
        REG_END:    thr.fin    <= pwdata[DUR_W-1:0];
        default:    ; // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DASH:   prdata = {{(CFG_DW-DUR_W){1'b0}}, thr.dash};
      REG_IGNORE: prdata = {{(CFG_DW-DUR_W){1'b0}}, thr.ignore};
      REG_END:    prdata = {{(CFG_DW-DUR_W){1'b0}}, thr.fin};
      default:    prdata = '0;
    endcase
  end

  // Front: threshold compare, ignored holds never enter the queue.
  mkd_front u_front (
    .key_in (key_in),
    .thr    (thr),
    .q_full (q_full),
    .push   (push)
  );

  // Short queue so a stalled output does not block key transfers at once.
  mkd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  // Back: shift register of elements, table decode, output register.
  mkd_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .sym_out (sym_out)
  );

endmodule

@@ tb/sv/morse_key_decoder_tb.sv @@
// Self-checking testbench for morse_key_decoder: key releases in, symbol indexes out.
// Keeps its own model of the dot/dash collector and Morse table and checks every transfer.
// Depends on mkd_pkg, mkd_if and morse_key_decoder.
module morse_key_decoder_tb import mkd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ELEMS   = 9;
  localparam int DRAIN       = 8;     // DUT path is a queue write, then the output register; leave margin
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off in the back-pressure test
  localparam int LIMIT       = 2000;  // cycles without any transfer before giving up

  // unmapped register slot, just past the end threshold
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum {HOLD_DOT, HOLD_DASH, HOLD_SKIP, HOLD_END} hold_kind_t;

  logic clk;
  logic rst;

  // APB-style register port
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  mkd_key_if key_if ();
  mkd_sym_if sym_if ();

  morse_key_decoder #(
    .MAX_ELEMENTS(MAX_ELEMS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .key_in (key_if),
    .sym_out(sym_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Morse patterns by symbol index: A-Z, 0-9, then SOS, BT, AR.
  string morse_patterns [NUM_SYMBOLS] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
    "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....",
    "--...", "---..", "----.",
    "...---...", "-...-", ".-.-."
  };

  // Predicted thresholds and collector state
  logic [DUR_W-1:0]     dash_thr;
  logic [DUR_W-1:0]     skip_thr;
  logic [DUR_W-1:0]     close_thr;
  logic [MAX_ELEMS-1:0] seq_bits;
  logic [CNT_W-1:0]     seq_len;
  logic                 seq_overflow;

  logic [SYM_W-1:0] expected_symbols [$];
  logic [SYM_W-1:0] want;

  // Idle mix: percent of cycles the sender idles / the receiver stalls
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic rx_hold = 1'b0;
  event hold_go;

  int releases_sent = 0;
  int releases_skipped = 0;
  int symbols_seen = 0;
  int cfg_writes = 0;
  int input_stall_cycles = 0;
  int errors = 0;
  int stuck_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Table lookup: first matching entry wins; empty or overflowed gives unknown.
  function automatic logic [SYM_W-1:0] decode_sequence(input logic [MAX_ELEMS-1:0] bits,
                                                       input logic [CNT_W-1:0] len,
                                                       input logic ovf);
    string pat;
    logic [15:0] code;
    if (ovf || len == 0) return SYM_UNKNOWN;
    for (int s = 0; s < NUM_SYMBOLS; s++) begin
      pat = morse_patterns[s];
      code = '0;
      for (int i = 0; i < pat.len(); i++) code = {code[14:0], pat[i] == "-"};
      if (pat.len() == int'(len) && code == 16'(bits)) return SYM_W'(s);
    end
    return SYM_UNKNOWN;
  endfunction

  // One accepted key release. The end test wins over the ignore test, which
  // wins over the dash test, however the thresholds are ordered.
  task automatic apply_release(input logic [DUR_W-1:0] dur);
    if (dur > close_thr) begin
      expected_symbols.push_back(decode_sequence(seq_bits, seq_len, seq_overflow));
      seq_bits = '0;
      seq_len = '0;
      seq_overflow = 1'b0;
    end else if (dur > skip_thr) begin
      releases_skipped++;
    end else if (seq_len >= MAX_ELEMS) begin
      // sequence full: element dropped, character will decode as unknown
      seq_overflow = 1'b1;
    end else begin
      seq_bits = {seq_bits[MAX_ELEMS-2:0], dur > dash_thr};
      seq_len = seq_len + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Duration that lands in the given class under the current thresholds,
  // sometimes right on a class boundary. Empty class: any duration.
  function automatic logic [DUR_W-1:0] rand_hold(input hold_kind_t kind);
    int lo;
    int hi;
    case (kind)
      HOLD_DOT: begin
        lo = 0;
        hi = int'(dash_thr);
        if (int'(skip_thr) < hi) hi = int'(skip_thr);
        if (int'(close_thr) < hi) hi = int'(close_thr);
      end
      HOLD_DASH: begin
        lo = int'(dash_thr) + 1;
        hi = (skip_thr < close_thr) ? int'(skip_thr) : int'(close_thr);
      end
      HOLD_SKIP: begin
        lo = int'(skip_thr) + 1;
        hi = int'(close_thr);
      end
      default: begin
        lo = int'(close_thr) + 1;
        hi = 65535;
      end
    endcase
    if (lo > hi) return DUR_W'($urandom_range(65535));
    if ($urandom_range(7) == 0) return DUR_W'($urandom_range(1) ? hi : lo);
    return DUR_W'($urandom_range(hi, lo));
  endfunction

  // Offer one key release and wait for its transfer. valid stays high after
  // the transfer so back-to-back items are not split by a glitch.
  task automatic send_release(input logic [DUR_W-1:0] dur);
    if ($urandom_range(99) < send_idle_pct) begin
      key_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    key_if.valid <= 1'b1;
    key_if.press_duration_ms <= dur;
    do @(posedge clk); while (!key_if.ready);
    apply_release(dur);
    releases_sent++;
  endtask

  // One character: mostly real table entries, then random patterns, too-long
  // sequences, and some plain noise.
  task automatic send_random_char();
    int pick;
    int len;
    int s;
    string pat;
    pick = $urandom_range(99);
    if (pick < 60) begin
      s = $urandom_range(NUM_SYMBOLS - 1);
      pat = morse_patterns[s];
      for (int i = 0; i < pat.len(); i++) begin
        if ($urandom_range(9) == 0) send_release(rand_hold(HOLD_SKIP));
        send_release(rand_hold(pat[i] == "-" ? HOLD_DASH : HOLD_DOT));
      end
      send_release(rand_hold(HOLD_END));
    end else if (pick < 82) begin
      len = (pick < 75) ? $urandom_range(MAX_ELEMS, 1)
                        : $urandom_range(MAX_ELEMS + 3, MAX_ELEMS + 1);
      repeat (len) send_release(rand_hold($urandom_range(1) ? HOLD_DASH : HOLD_DOT));
      send_release(rand_hold(HOLD_END));
    end else begin
      repeat ($urandom_range(4, 1)) send_release(DUR_W'($urandom_range(65535)));
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = releases_sent + n;
    while (releases_sent < target) send_random_char();
  endtask

  // Let the DUT go quiet: no offer, every symbol back, then the pipeline latency
  // in case a release that makes no symbol is still on its way through.
  task automatic settle();
    key_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DASH:   dash_thr = value[DUR_W-1:0];
      REG_IGNORE: skip_thr = value[DUR_W-1:0];
      REG_END:    close_thr = value[DUR_W-1:0];
      default:    ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_thresholds(input int dash_ms, input int skip_ms, input int close_ms);
    write_reg(REG_DASH, CFG_DW'(dash_ms));
    write_reg(REG_IGNORE, CFG_DW'(skip_ms));
    write_reg(REG_END, CFG_DW'(close_ms));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds, each class boundary, empty character, max duration.
  task automatic test_boundaries();
    send_release(16'hFFFF);            // end with nothing collected
    send_release(DASH_RESET);          // dot, on the dash threshold
    send_release(IGNORE_RESET + 1'b1); // dropped
    send_release(IGNORE_RESET);        // dash, on the ignore threshold
    send_release(END_RESET);           // dropped, on the end threshold
    send_release(END_RESET + 1'b1);    // ".-"
    send_release(DASH_RESET + 1'b1);   // dash
    send_release(END_RESET + 1'b1);    // "-"
    send_release(16'd0);
    send_release(16'hFFFF);            // "."
  endtask

  // One element more than the collector holds, then end: unknown.
  task automatic test_overflow();
    for (int i = 0; i <= MAX_ELEMS; i++) send_release(i[0] ? 16'd0 : IGNORE_RESET);
    send_release(END_RESET + 1'b1);
  endtask

  // Small and minimal thresholds, with idle sender and then stalled receiver.
  task automatic test_threshold_ranges();
    send_idle_pct = 81;
    recv_stall_pct = 0;
    set_thresholds(10, 40, 100);
    run_random(250);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    set_thresholds(0, 1, 2);
    run_random(200);
  endtask

  // Everything at maximum: nothing ends, every element a dot, the collector
  // overflows. The first end after lowering the thresholds must give unknown.
  task automatic test_saturated_thresholds();
    send_idle_pct = 34;
    recv_stall_pct = 34;
    set_thresholds(65535, 65535, 65535);
    repeat (40) send_release(DUR_W'($urandom_range(65535)));
    set_thresholds(200, 600, 1500);
    run_random(100);
  endtask

  // Thresholds in reverse order: end must be tested before ignore and dash.
  task automatic test_threshold_priority();
    send_idle_pct = 34;
    recv_stall_pct = 34;
    set_thresholds(5000, 800, 300);
    run_random(150);
  endtask

  // Unmapped slot is dropped; upper data bits are not part of a threshold.
  task automatic test_register_decode();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_SPARE, 32'hFFFF_0005);
    write_reg(REG_DASH, 32'hABCD_0100);
    write_reg(REG_IGNORE, 32'h5A5A_03E8);
    write_reg(REG_END, 32'hF0F0_07D0);
    run_random(100);
  endtask

  // Receiver holds off while short characters keep coming, so the output
  // register and queue fill and the key input must stall.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    -> hold_go;
    repeat (30) begin
      send_release(rand_hold(HOLD_DOT));
      send_release(rand_hold(HOLD_END));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rx_hold) begin
      sym_if.ready <= 1'b0;
    end else begin
      sym_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always begin
    @(hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Compare each symbol transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && key_if.valid && !key_if.ready) input_stall_cycles++;
    if (!rst && sym_if.valid && sym_if.ready) begin
      symbols_seen++;
      if (expected_symbols.size() == 0) begin
        errors++;
        $display("%0t: symbol_index expected none, got %0d", $time, sym_if.symbol_index);
      end else begin
        want = expected_symbols.pop_front();
        if (sym_if.symbol_index !== want) begin
          errors++;
          $display("%0t: symbol_index expected %0d, got %0d", $time, want,
                   sym_if.symbol_index);
        end
      end
    end
  end

  // Any transfer on any port counts as progress.
  always @(posedge clk) begin
    if ((key_if.valid && key_if.ready) || (sym_if.valid && sym_if.ready) ||
        (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    key_if.valid <= 1'b0;
    key_if.press_duration_ms <= '0;
    dash_thr = DASH_RESET;
    skip_thr = IGNORE_RESET;
    close_thr = END_RESET;
    seq_bits = '0;
    seq_len = '0;
    seq_overflow = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset thresholds, no idling
    test_boundaries();
    test_overflow();
    run_random(260);

    test_threshold_ranges();
    test_saturated_thresholds();
    test_threshold_priority();
    test_register_decode();
    test_backpressure();

    // back to reset values with both sides idling
    send_idle_pct = 34;
    recv_stall_pct = 34;
    set_thresholds(int'(DASH_RESET), int'(IGNORE_RESET), int'(END_RESET));
    run_random(160);

    settle();
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d key releases (%0d dropped as too long), checked %0d symbols,",
             releases_sent, releases_skipped, symbols_seen);
    $display("over %0d register writes; key input stalled for %0d cycles.",
             cfg_writes, input_stall_cycles);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
